### sv/ias_pkg.sv
package ias_pkg;

	localparam int unsigned DefStackDepth = 128;
	localparam int unsigned ValueWidth    = 32;
	localparam int unsigned IndexWidth    = 8;
	localparam int unsigned CountOutWidth = 8;

	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_POP    = 2'd1,
		REQ_PEEK   = 2'd2,
		REQ_CHANGE = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2
	} status_code_t;

	typedef enum logic {
		S_IDLE,
		S_RESULT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load_out;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
	} dp_status_t;

endpackage

### sv/ias_req_if.sv
interface ias_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] value;
	logic [7:0]         depth_index;

	modport source (output valid, output req_type, output value, output depth_index,
		input ready);
	modport sink (input valid, input req_type, input value, input depth_index,
		output ready);
endinterface

### sv/ias_rsp_if.sv
interface ias_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] data;
	logic [1:0]         status;
	logic [7:0]         count;

	modport source (output valid, output data, output status, output count,
		input ready);
	modport sink (input valid, input data, input status, input count,
		output ready);
endinterface

### sv/ias_ram.sv
module ias_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 128,
	localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AddrWidth-1:0] waddr,
	input  logic [Width-1:0]     wdata,
	input  logic                 re,
	input  logic [AddrWidth-1:0] raddr,
	output logic [Width-1:0]     rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/ias_ctrl.sv
module ias_ctrl
	import ias_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t dp_status,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_next = S_RESULT;
				end
			end
			S_RESULT: begin
				if (dp_status.slot_free) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_RESULT: begin
				cmd.load_out = dp_status.slot_free;
			end
			default: ;
		endcase
	end

endmodule

### sv/ias_datapath.sv
module ias_datapath
	import ias_pkg::*;
#(
	parameter int unsigned StackDepth = DefStackDepth
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctrl_cmd_t                    cmd,
	output dp_status_t                   dp_status,
	input  logic [1:0]                   req_type,
	input  logic signed [ValueWidth-1:0] value,
	input  logic [IndexWidth-1:0]        depth_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [ValueWidth-1:0] out_data,
	output logic [1:0]                   out_status,
	output logic [CountOutWidth-1:0]     out_count
);

	localparam int unsigned AddrWidth  = $clog2(StackDepth);
	localparam int unsigned CountWidth = $clog2(StackDepth + 1);
	localparam int unsigned CmpWidth   = CountWidth + IndexWidth + CountOutWidth;

	// stack state
	logic [CountWidth-1:0] count_q, count_next;

	// request held while the read completes
	status_code_t          status_q, status_next;
	logic                  use_ram_q, use_ram_next;
	logic [ValueWidth-1:0] word_q, word_next;

	// output register
	logic                         out_valid_q;
	logic signed [ValueWidth-1:0] out_data_q;
	logic [1:0]                   out_status_q;
	logic [CountOutWidth-1:0]     out_count_q;

	// ram port signals
	logic                  ram_we, ram_re;
	logic [AddrWidth-1:0]  ram_waddr, ram_raddr;
	logic [ValueWidth-1:0] ram_rdata;

	logic [CmpWidth-1:0] count_ext, depth_ext, pos_ext;
	logic                is_full, is_empty, depth_bad;

	assign count_ext = CmpWidth'(count_q);
	assign depth_ext = CmpWidth'(depth_index);
	assign pos_ext   = count_ext - depth_ext;
	assign is_full   = (count_ext == CmpWidth'(StackDepth));
	assign is_empty  = (count_q == '0);
	assign depth_bad = (depth_index == '0) || (depth_ext > count_ext);

	always_comb begin
		count_next   = count_q;
		status_next  = ST_OK;
		use_ram_next = 1'b0;
		word_next    = '0;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		ram_waddr    = pos_ext[AddrWidth-1:0];
		ram_raddr    = pos_ext[AddrWidth-1:0];
		unique case (req_kind_t'(req_type))
			REQ_PUSH: begin
				ram_waddr = count_ext[AddrWidth-1:0];
				if (is_full) begin
					status_next = ST_OVER;
				end else begin
					ram_we     = cmd.accept;
					count_next = count_q + CountWidth'(1);
				end
			end
			REQ_POP: begin
				ram_raddr = count_next[AddrWidth-1:0];
				if (is_empty) begin
					status_next = ST_UNDER;
				end else begin
					count_next   = count_q - CountWidth'(1);
					ram_raddr    = count_next[AddrWidth-1:0];
					ram_re       = cmd.accept;
					use_ram_next = 1'b1;
				end
			end
			REQ_PEEK: begin
				if (depth_bad) begin
					status_next = ST_UNDER;
				end else begin
					ram_re       = cmd.accept;
					use_ram_next = 1'b1;
				end
			end
			REQ_CHANGE: begin
				if (depth_bad) begin
					status_next = ST_UNDER;
				end else begin
					ram_we    = cmd.accept;
					word_next = value;
				end
			end
			default: status_next = ST_UNDER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.accept) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_q  <= status_next;
			use_ram_q <= use_ram_next;
			word_q    <= word_next;
		end
	end

	ias_ram #(
		.Width(ValueWidth),
		.Depth(StackDepth)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign dp_status.slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q   <= use_ram_q ? ram_rdata : word_q;
			out_status_q <= status_q;
			out_count_q  <= count_ext[CountOutWidth-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_status = out_status_q;
	assign out_count  = out_count_q;

endmodule

### sv/indexed_array_stack_core.sv
// channel  modport  transfer carries
// req      sink     req_type, value, depth_index
// rsp      source   data, status, count
//
// a request passes through the idle and result states: the stack memory has a registered
// read port, so a pop or peek word is ready in the cycle after the request transfer
// push, change and the element count are updated at the request transfer itself
// a result waits in the output register while rsp is stalled; the next request is taken
// once that result has moved into the output register
// reset clears the element count and the handshake state; the memory needs no clearing
module indexed_array_stack_core
	import ias_pkg::*;
#(
	parameter int unsigned StackDepth = DefStackDepth
) (
	input logic   clk,
	input logic   arst_n,
	ias_req_if.sink   req,
	ias_rsp_if.source rsp
);

	// command and status between the sequencer and the datapath
	ctrl_cmd_t  cmd;
	dp_status_t dp_status;

	// sequencer: idle, or holding one request until its result is registered
	ias_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.dp_status(dp_status),
		.cmd      (cmd)
	);

	// datapath: element count, stack memory, request checks and output register
	ias_datapath #(
		.StackDepth(StackDepth)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.dp_status  (dp_status),
		.req_type   (req.req_type),
		.value      (req.value),
		.depth_index(req.depth_index),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_data   (rsp.data),
		.out_status (rsp.status),
		.out_count  (rsp.count)
	);

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ias_pkg::*;

	localparam int unsigned Depth       = DefStackDepth;
	localparam int unsigned RandomReqs  = 850;
	// each idling phase lasts this many request transfers
	localparam int unsigned PhaseLen    = 110;
	// long receiver hold-off starts once this many requests have gone in
	localparam int unsigned PressureAt  = 450;
	localparam int unsigned HoldCycles  = 80;
	localparam int unsigned WatchdogMax = 3000;
	// settle time after the last result
	localparam int unsigned TailCycles  = 10;

	typedef enum int unsigned {
		PH_BUSY,
		PH_SRC_IDLE,
		PH_SNK_STALL,
		PH_BOTH
	} idle_phase_t;

	typedef struct {
		req_kind_t          kind;
		logic signed [31:0] word;
		logic [7:0]         depth;
	} stack_req_t;

	typedef struct {
		logic signed [31:0] data;
		status_code_t       status;
		logic [7:0]         count;
	} stack_rsp_t;

	logic clk;
	logic arst_n;

	ias_req_if req_ch ();
	ias_rsp_if rsp_ch ();

	indexed_array_stack_core #(
		.StackDepth(Depth)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// requests still to be offered, in order
	stack_req_t req_todo_q[$];
	// results owed by the block, oldest first
	stack_rsp_t rsp_due_q[$];

	// shadow copy of the stack, advanced at each request transfer
	logic signed [31:0] shadow_words [Depth];
	int unsigned        shadow_fill;

	// element count as seen by the stimulus builder, to aim depths at live entries
	int unsigned gen_fill;

	int unsigned sent_reqs;
	int unsigned hold_left;
	logic        hold_done;
	int unsigned quiet_cycles;
	int unsigned fail_cnt;

	// ------------------------------------------------------------------
	// clock and the single reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_PUSH;
		req_ch.value       = '0;
		req_ch.depth_index = '0;
		rsp_ch.ready       = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// predictor: applies one request to the shadow stack and returns the
	// result the block owes for it
	// ------------------------------------------------------------------
	function automatic stack_rsp_t apply_stack_op(req_kind_t kind, logic signed [31:0] word,
		logic [7:0] depth);
		stack_rsp_t  r;
		int unsigned slot;
		r.data   = '0;
		r.status = ST_OK;
		case (kind)
			REQ_PUSH: begin
				// full stack refuses the push and keeps its contents
				if (shadow_fill >= Depth) begin
					r.status = ST_OVER;
				end else begin
					shadow_words[shadow_fill] = word;
					shadow_fill++;
				end
			end
			REQ_POP: begin
				// empty stack refuses the pop
				if (shadow_fill == 0) begin
					r.status = ST_UNDER;
				end else begin
					shadow_fill--;
					r.data = shadow_words[shadow_fill];
				end
			end
			default: begin
				// peek and change: depth zero or past the count is refused, nothing written
				if (depth == 0 || depth > shadow_fill) begin
					r.status = ST_UNDER;
				end else begin
					slot = shadow_fill - depth;
					if (kind == REQ_CHANGE) begin
						shadow_words[slot] = word;
					end
					r.data = shadow_words[slot];
				end
			end
		endcase
		r.count = 8'(shadow_fill);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------
	task automatic add_req(req_kind_t kind, logic signed [31:0] word, logic [7:0] depth);
		stack_req_t r;
		r.kind  = kind;
		r.word  = word;
		r.depth = depth;
		req_todo_q.push_back(r);
		if (kind == REQ_PUSH && gen_fill < Depth) begin
			gen_fill++;
		end else if (kind == REQ_POP && gen_fill != 0) begin
			gen_fill--;
		end
	endtask

	// extremes turn up often, the rest is uniform
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 32'sh0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// mostly a live depth, sometimes zero, one past the top or anywhere in range
	function automatic logic [7:0] pick_depth(int unsigned fill);
		int unsigned r;
		r = $urandom_range(9);
		if (fill != 0 && r < 7) begin
			return 8'($urandom_range(fill, 1));
		end else if (r == 7) begin
			return 8'd0;
		end else if (r == 8) begin
			return 8'((fill < Depth) ? fill + 1 : Depth);
		end
		return 8'($urandom_range(Depth, 0));
	endfunction

	task automatic add_random_req(int unsigned push_pct);
		req_kind_t kind;
		if ($urandom_range(99) < push_pct) begin
			kind = REQ_PUSH;
		end else begin
			case ($urandom_range(2))
				0: kind = REQ_POP;
				1: kind = REQ_PEEK;
				default: kind = REQ_CHANGE;
			endcase
		end
		add_req(kind, pick_word(), pick_depth(gen_fill));
	endtask

	task automatic build_stimulus();
		int unsigned n_rand;
		int unsigned seg;
		int unsigned len;
		int unsigned bias [4];
		bias = '{85, 55, 30, 10};

		// directed: empty stack first
		add_req(REQ_POP, 32'sh1234_5678, 8'd0);
		add_req(REQ_PEEK, 32'sh0, 8'd1);
		add_req(REQ_CHANGE, 32'sh5555_aaaa, 8'd1);
		// extreme words
		add_req(REQ_PUSH, 32'sh7fff_ffff, 8'd0);
		add_req(REQ_PUSH, 32'sh8000_0000, 8'd255);
		add_req(REQ_PUSH, 32'sh0, 8'd0);
		add_req(REQ_PUSH, -32'sd1, 8'd0);
		// depth edges on a four-deep stack
		add_req(REQ_PEEK, 32'sh0, 8'd0);
		add_req(REQ_PEEK, 32'sh0, 8'd1);
		add_req(REQ_PEEK, 32'sh0, 8'd4);
		add_req(REQ_PEEK, 32'sh0, 8'd5);
		add_req(REQ_PEEK, 32'sh0, 8'd128);
		add_req(REQ_CHANGE, 32'sh8000_0000, 8'd2);
		add_req(REQ_CHANGE, 32'sh7fff_ffff, 8'd0);
		add_req(REQ_CHANGE, 32'sh7fff_ffff, 8'd5);
		add_req(REQ_PEEK, 32'sh0, 8'd2);
		// drain and pop once too many
		repeat (5) add_req(REQ_POP, 32'sh0, 8'd0);

		// random: segments with varying push bias so the stack rises and falls
		n_rand = 0;
		seg    = 0;
		while (n_rand < RandomReqs) begin
			if (seg == 2) begin
				// fill past the top, then work at the deepest entry
				repeat (Depth + 7) add_req(REQ_PUSH, pick_word(), pick_depth(gen_fill));
				add_req(REQ_PEEK, pick_word(), 8'd128);
				add_req(REQ_CHANGE, pick_word(), 8'd128);
				add_req(REQ_PEEK, pick_word(), 8'd128);
				add_req(REQ_POP, pick_word(), pick_depth(gen_fill));
				n_rand += Depth + 11;
			end else begin
				len = $urandom_range(80, 20);
				repeat (len) add_random_req(bias[$urandom_range(3)]);
				n_rand += len;
			end
			seg++;
		end
	endtask

	// ------------------------------------------------------------------
	// idling phases, stepped by the number of request transfers
	// ------------------------------------------------------------------
	function automatic idle_phase_t phase_of(int unsigned n);
		return idle_phase_t'((n / PhaseLen) % 4);
	endfunction

	function automatic int unsigned src_idle_pct(idle_phase_t ph);
		case (ph)
			PH_SRC_IDLE: return 51;
			PH_BOTH: return 27;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned snk_stall_pct(idle_phase_t ph);
		case (ph)
			PH_SNK_STALL: return 51;
			PH_BOTH: return 27;
			default: return 0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// request driver: predicts on each transfer, then offers the next item
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		stack_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			sent_reqs    <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				rsp_due_q.push_back(apply_stack_op(req_kind_t'(req_ch.req_type), req_ch.value,
					req_ch.depth_index));
				sent_reqs <= sent_reqs + 1;
			end
			// valid only drops or moves on once the current item has gone
			if (!req_ch.valid || req_ch.ready) begin
				if (req_todo_q.size() != 0
					&& $urandom_range(99) >= src_idle_pct(phase_of(sent_reqs))) begin
					nxt = req_todo_q.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.req_type    <= nxt.kind;
					req_ch.value       <= nxt.word;
					req_ch.depth_index <= nxt.depth;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor: checks each transfer against the oldest owed result
	// and drives ready, including one long hold-off to back the block up
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		stack_rsp_t due;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (rsp_due_q.size() == 0) begin
					$error("rsp transfer with no result owed: data %0d status %0d count %0d",
						rsp_ch.data, rsp_ch.status, rsp_ch.count);
					fail_cnt += 1;
				end else begin
					due = rsp_due_q.pop_front();
					if (rsp_ch.data !== due.data) begin
						$error("data mismatch: expected %0d, actual %0d", due.data, rsp_ch.data);
						fail_cnt += 1;
					end
					if (rsp_ch.status !== due.status) begin
						$error("status mismatch: expected %0d, actual %0d", due.status,
							rsp_ch.status);
						fail_cnt += 1;
					end
					if (rsp_ch.count !== due.count) begin
						$error("count mismatch: expected %0d, actual %0d", due.count,
							rsp_ch.count);
						fail_cnt += 1;
					end
				end
			end
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left    <= hold_left - 1;
			end else if (!hold_done && sent_reqs >= PressureAt) begin
				// sender keeps offering meanwhile, so the input side must stall
				rsp_ch.ready <= 1'b0;
				hold_left    <= HoldCycles;
				hold_done    <= 1'b1;
			end else begin
				rsp_ch.ready <= $urandom_range(99) >= snk_stall_pct(phase_of(sent_reqs));
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long without any transfer on either channel
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogMax) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// run control
	// ------------------------------------------------------------------
	initial begin
		shadow_fill = 0;
		gen_fill    = 0;
		fail_cnt    = 0;
		build_stimulus();
		@(posedge arst_n);
		// sample away from the active edge so queue updates have settled
		while (req_todo_q.size() != 0 || req_ch.valid || rsp_due_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (TailCycles) @(negedge clk);
		if (rsp_due_q.size() != 0) begin
			$error("%0d results still owed at the end", rsp_due_q.size());
			fail_cnt += 1;
		end
		if (fail_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
